@@ rtl/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled during reset
`define HCB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// implication form of the same
`define HCB_ASSERT_IMP(lbl, cond, prop, msg) \
    `HCB_ASSERT(lbl, (cond) |-> (prop), msg)

`endif

@@ rtl/hcb_pkg.sv @@
// ----------------------------------------------------------------------------
// hcb_pkg
// Constants, types and helpers of the Huffman code builder.
// ----------------------------------------------------------------------------
package hcb_pkg;

    localparam int MAX_SYMBOLS = 32;
    localparam int IDX_W       = 5;   // leaf index
    localparam int CNT_W       = 6;   // symbol count, holds MAX_SYMBOLS
    localparam int NODE_W      = 6;   // tree node index
    localparam int NODE_CAP    = 2 * MAX_SYMBOLS;
    localparam int FREQ_BITS   = 20;
    localparam int LABEL_W     = 8;
    localparam int WGT_W       = 26;
    localparam int LEN_W       = 5;
    localparam int CODE_W      = 31;
    localparam int FIX_W       = 28;
    localparam int COD_W       = 30;
    localparam int LG_W        = 3;
    localparam int KEY_W       = FREQ_BITS + LABEL_W;
    localparam int IN_DATA_W   = 32;
    localparam int OUT_DATA_W  = 104;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_SORT,
        ST_MERGE,
        ST_TR_REQ,
        ST_TR_UPD,
        ST_EMIT,
        ST_SUM
    } hcb_state_t;

    typedef struct packed {
        logic [LABEL_W-1:0] out_symbol;
        logic [LEN_W-1:0]   code_length;
        logic [CODE_W-1:0]  codeword;
        logic               is_summary;
        logic [FIX_W-1:0]   fixed_size;
        logic [COD_W-1:0]   coded_size;
        logic               last_result;
    } hcb_result_t;

    // ceil(log2 n) for a symbol count
    function automatic logic [LG_W-1:0] ceil_log2(input logic [CNT_W-1:0] n);
        logic [CNT_W:0]  prod;
        logic [LG_W-1:0] lg;
        prod = (CNT_W+1)'(1);
        lg   = '0;
        for (int k = 0; k < CNT_W; k++) begin
            if (prod < {1'b0, n}) begin
                lg   = lg + LG_W'(1);
                prod = {prod[CNT_W-1:0], 1'b0};
            end
        end
        return lg;
    endfunction

endpackage

@@ rtl/huffman_code_builder.sv @@
// ----------------------------------------------------------------------------
// huffman_code_builder
// Binary Huffman code builder: loads symbols, sorts, merges with two queues,
// traces each leaf to the root and reports codes and size totals.
// ----------------------------------------------------------------------------
// channel | dir | tdata                          | tuser      | tlast
// s_      | in  | symbol_id, frequency           | -          | last_symbol
// m_      | out | symbol, length, code, sizes    | is_summary | last_result
//
// loading takes one transfer per cycle; the last symbol starts the build
// sort: selection by one key comparator, scanning all n leaves for each rank
// merge: the two children of each internal node in turn; trace: request and update states per tree level
// result register takes the next result at the edge of each transfer
// s_tready is low from the last symbol until the summary is in the register
// reset is synchronous and active low, the stores need no clearing
// ----------------------------------------------------------------------------
module huffman_code_builder import hcb_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [IN_DATA_W-1:0]  s_tdata,   // symbol_id[7:0], frequency[27:8]
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,   // out_symbol, code_length, codeword,
                                             // fixed_size, coded_size
    output logic                  m_tuser,   // is_summary
    output logic                  m_tlast
);

    hcb_state_t state_reg, state_next;

    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic [CNT_W-1:0]  n_reg, n_next;
    logic [IDX_W-1:0]  r_reg, r_next;
    logic [IDX_W-1:0]  s_reg, s_next;
    logic              have_reg, have_next;
    logic [KEY_W-1:0]  best_key_reg, best_key_next;
    logic [IDX_W-1:0]  best_idx_reg, best_idx_next;
    logic [MAX_SYMBOLS-1:0] taken_reg, taken_next;
    logic [CNT_W-1:0]  p1_reg, p1_next;
    logic [IDX_W-1:0]  p2_reg, p2_next;
    logic [IDX_W-1:0]  m_reg, m_next;
    logic              j_reg, j_next;
    logic [WGT_W-1:0]  w_reg, w_next;
    logic [WGT_W-1:0]  total_reg, total_next;
    logic [CNT_W-1:0]  i_reg, i_next;
    logic [NODE_W-1:0] node_reg, node_next;
    logic [LEN_W-1:0]  len_reg, len_next;
    logic [CODE_W-1:0] code_reg, code_next;
    logic [COD_W-1:0]  coded_reg, coded_next;

    // stores
    logic [FREQ_BITS-1:0] leaf_freq    [MAX_SYMBOLS];
    logic [LABEL_W-1:0]   leaf_label   [MAX_SYMBOLS];
    logic [FREQ_BITS-1:0] sorted_freq  [MAX_SYMBOLS];
    logic [IDX_W-1:0]     sorted_order [MAX_SYMBOLS];
    logic [WGT_W-1:0]     merged_weight[MAX_SYMBOLS];
    logic [NODE_W-1:0]    node_parent  [NODE_CAP];
    logic                 node_bit     [NODE_CAP];
    logic [NODE_W-1:0]    parent_rd;
    logic                 bit_rd;

    logic in_xfer;
    logic leaf_we, sort_we, mw_we, node_we, node_re;
    logic [NODE_W-1:0] node_wa;
    logic [NODE_W-1:0] node_wd;
    logic              node_wb;
    logic              push, slot_free;
    hcb_result_t       item;

    // loop temporaries
    logic [IDX_W-1:0]     last_idx;
    logic [KEY_W-1:0]     cur_key;
    logic                 cand;
    logic [IDX_W-1:0]     pick_idx;
    logic [FREQ_BITS-1:0] lf;
    logic [WGT_W-1:0]     mw;
    logic                 leaf_ok;
    logic [WGT_W-1:0]     cw;
    logic [NODE_W-1:0]    root;
    logic [COD_W-1:0]     prod;
    logic [CNT_W-1:0]     n_new;

    assign s_tready = (state_reg == ST_LOAD);
    assign in_xfer  = s_tvalid && s_tready;
    assign last_idx = IDX_W'(n_reg - CNT_W'(1));
    assign root     = NODE_W'({n_reg, 1'b0} - (CNT_W+1)'(2));
    assign n_new    = (cnt_reg < CNT_W'(MAX_SYMBOLS)) ? cnt_reg + CNT_W'(1) : cnt_reg;

    // sort compare: unselected leaf with smaller key wins, first index on ties
    assign cur_key  = {leaf_freq[s_reg], leaf_label[s_reg]};
    assign cand     = !taken_reg[s_reg] && (!have_reg || (cur_key < best_key_reg));
    assign pick_idx = cand ? s_reg : best_idx_reg;

    // two-queue head compare, merged node first on equal weight
    assign lf      = sorted_freq[p1_reg[IDX_W-1:0]];
    assign mw      = merged_weight[p2_reg];
    assign leaf_ok = (p1_reg < n_reg) && ((p2_reg >= m_reg) || (WGT_W'(lf) < mw));
    assign cw      = leaf_ok ? WGT_W'(lf) : mw;

    assign prod = COD_W'(len_reg) * COD_W'(leaf_freq[i_reg[IDX_W-1:0]]);

    // leaf store
    always_ff @(posedge aclk) begin
        if (leaf_we) begin
            leaf_label[cnt_reg[IDX_W-1:0]] <= s_tdata[LABEL_W-1:0];
            leaf_freq[cnt_reg[IDX_W-1:0]]  <= s_tdata[LABEL_W +: FREQ_BITS];
        end
    end

    // sorted leaf queue
    always_ff @(posedge aclk) begin
        if (sort_we) begin
            sorted_order[r_reg] <= pick_idx;
            sorted_freq[r_reg]  <= leaf_freq[pick_idx];
        end
    end

    // merged node queue
    always_ff @(posedge aclk) begin
        if (mw_we) begin
            merged_weight[m_reg] <= w_reg + cw;
        end
    end

    // tree links, registered read
    always_ff @(posedge aclk) begin
        if (node_we) begin
            node_parent[node_wa] <= node_wd;
            node_bit[node_wa]    <= node_wb;
        end
        if (node_re) begin
            parent_rd <= node_parent[node_reg];
            bit_rd    <= node_bit[node_reg];
        end
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            cnt_reg   <= '0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        n_reg        <= n_next;
        r_reg        <= r_next;
        s_reg        <= s_next;
        have_reg     <= have_next;
        best_key_reg <= best_key_next;
        best_idx_reg <= best_idx_next;
        taken_reg    <= taken_next;
        p1_reg       <= p1_next;
        p2_reg       <= p2_next;
        m_reg        <= m_next;
        j_reg        <= j_next;
        w_reg        <= w_next;
        total_reg    <= total_next;
        i_reg        <= i_next;
        node_reg     <= node_next;
        len_reg      <= len_next;
        code_reg     <= code_next;
        coded_reg    <= coded_next;
    end

    // sequencer
    always_comb begin
        state_next    = state_reg;
        cnt_next      = cnt_reg;
        n_next        = n_reg;
        r_next        = r_reg;
        s_next        = s_reg;
        have_next     = have_reg;
        best_key_next = best_key_reg;
        best_idx_next = best_idx_reg;
        taken_next    = taken_reg;
        p1_next       = p1_reg;
        p2_next       = p2_reg;
        m_next        = m_reg;
        j_next        = j_reg;
        w_next        = w_reg;
        total_next    = total_reg;
        i_next        = i_reg;
        node_next     = node_reg;
        len_next      = len_reg;
        code_next     = code_reg;
        coded_next    = coded_reg;
        leaf_we       = 1'b0;
        sort_we       = 1'b0;
        mw_we         = 1'b0;
        node_we       = 1'b0;
        node_re       = 1'b0;
        node_wa       = leaf_ok ? NODE_W'(sorted_order[p1_reg[IDX_W-1:0]])
                                : n_reg + NODE_W'(p2_reg);
        node_wd       = n_reg + NODE_W'(m_reg);
        node_wb       = j_reg;
        push          = 1'b0;
        item          = '0;

        case (state_reg)
            ST_LOAD: begin
                if (in_xfer) begin
                    leaf_we  = (cnt_reg < CNT_W'(MAX_SYMBOLS));
                    cnt_next = n_new;
                    if (s_tlast) begin
                        cnt_next   = '0;
                        n_next     = n_new;
                        r_next     = '0;
                        s_next     = '0;
                        have_next  = 1'b0;
                        taken_next = '0;
                        i_next     = '0;
                        len_next   = '0;
                        code_next  = '0;
                        coded_next = '0;
                        total_next = '0;
                        if (n_new < CNT_W'(2)) begin
                            state_next = ST_EMIT;
                        end else begin
                            state_next = ST_SORT;
                        end
                    end
                end
            end

            // one leaf key compared per cycle
            ST_SORT: begin
                if (s_reg == last_idx) begin
                    sort_we    = 1'b1;
                    taken_next = taken_reg | (MAX_SYMBOLS'(1) << pick_idx);
                    have_next  = 1'b0;
                    s_next     = '0;
                    r_next     = r_reg + IDX_W'(1);
                    if (r_reg == last_idx) begin
                        p1_next    = '0;
                        p2_next    = '0;
                        m_next     = '0;
                        j_next     = 1'b0;
                        state_next = ST_MERGE;
                    end
                end else begin
                    s_next = s_reg + IDX_W'(1);
                    if (cand) begin
                        have_next     = 1'b1;
                        best_key_next = cur_key;
                        best_idx_next = s_reg;
                    end
                end
            end

            // one child taken per cycle
            ST_MERGE: begin
                node_we = 1'b1;
                if (leaf_ok) begin
                    p1_next = p1_reg + CNT_W'(1);
                end else begin
                    p2_next = p2_reg + IDX_W'(1);
                end
                if (!j_reg) begin
                    w_next = cw;
                    j_next = 1'b1;
                end else begin
                    mw_we  = 1'b1;
                    j_next = 1'b0;
                    m_next = m_reg + IDX_W'(1);
                    if (m_reg == IDX_W'(n_reg - CNT_W'(2))) begin
                        total_next = w_reg + cw;
                        node_next  = '0;
                        state_next = ST_TR_REQ;
                    end
                end
            end

            ST_TR_REQ: begin
                if (node_reg == root) begin
                    state_next = ST_EMIT;
                end else begin
                    node_re    = 1'b1;
                    state_next = ST_TR_UPD;
                end
            end

            ST_TR_UPD: begin
                if (len_reg < LEN_W'(CODE_W)) begin
                    code_next[len_reg] = bit_rd;
                end
                len_next   = len_reg + LEN_W'(1);
                node_next  = parent_rd;
                state_next = ST_TR_REQ;
            end

            ST_EMIT: begin
                if (slot_free) begin
                    push             = 1'b1;
                    item.out_symbol  = leaf_label[i_reg[IDX_W-1:0]];
                    item.code_length = len_reg;
                    item.codeword    = code_reg;
                    coded_next       = coded_reg + prod;
                    i_next           = i_reg + CNT_W'(1);
                    len_next         = '0;
                    code_next        = '0;
                    node_next        = NODE_W'(i_reg + CNT_W'(1));
                    if (i_reg + CNT_W'(1) == n_reg) begin
                        state_next = ST_SUM;
                    end else begin
                        state_next = ST_TR_REQ;
                    end
                end
            end

            ST_SUM: begin
                if (slot_free) begin
                    push             = 1'b1;
                    item.is_summary  = 1'b1;
                    item.last_result = 1'b1;
                    item.fixed_size  = FIX_W'(ceil_log2(n_reg)) * FIX_W'(total_reg);
                    item.coded_size  = coded_reg;
                    state_next       = ST_LOAD;
                end
            end

            default: begin
                state_next = ST_LOAD;
            end
        endcase
    end

    hcb_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .item      (item),
        .slot_free (slot_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

endmodule

@@ rtl/hcb_out_reg.sv @@
// ----------------------------------------------------------------------------
// hcb_out_reg
// Result register of the code builder: holds one result until transfer.
// ----------------------------------------------------------------------------
module hcb_out_reg import hcb_pkg::*; (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  hcb_result_t           item,
    output logic                  slot_free,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [OUT_DATA_W-1:0] m_tdata,
    output logic                  m_tuser,
    output logic                  m_tlast
);

    logic        valid_reg;
    hcb_result_t data_reg;

    assign slot_free = !valid_reg || m_tready;

    // valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (push) begin
            valid_reg <= 1'b1;
        end else if (m_tready) begin
            valid_reg <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge aclk) begin
        if (push) begin
            data_reg <= item;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {2'b00, data_reg.coded_size, data_reg.fixed_size,
                       data_reg.codeword, data_reg.code_length, data_reg.out_symbol};
    assign m_tuser  = data_reg.is_summary;
    assign m_tlast  = data_reg.last_result;

endmodule

@@ rtl/hcb_checker.sv @@
// ----------------------------------------------------------------------------
// hcb_checker
// Port-level checks of the Huffman code builder.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module hcb_checker import hcb_pkg::*; (
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  s_tvalid,
    input logic                  s_tready,
    input logic                  s_tlast,
    input logic                  m_tvalid,
    input logic                  m_tready,
    input logic [OUT_DATA_W-1:0] m_tdata,
    input logic                  m_tuser,
    input logic                  m_tlast
);

    // a stalled result stays offered
    `HCB_ASSERT_IMP(a_hold, m_tvalid && !m_tready, ##1 m_tvalid, "result dropped while stalled")
    // only the summary closes a run
    `HCB_ASSERT_IMP(a_last, m_tvalid, m_tuser == m_tlast, "summary and last flag disagree")
    // the summary carries no symbol and a zero code length
    `HCB_ASSERT_IMP(a_sum, m_tvalid && m_tuser, m_tdata[12:0] == 13'd0, "code on summary")
    // the last symbol closes the input until the build is done
    `HCB_ASSERT_IMP(a_busy, s_tvalid && s_tready && s_tlast, ##1 !s_tready,
                    "input open after last symbol")

endmodule

bind huffman_code_builder hcb_checker u_hcb_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
